### hdl/mbpm_pkg.sv
// Package with shared types, codes and constants of the byte pattern matcher.
`default_nettype none
package mbpm_pkg;
  localparam int unsigned ProgDepth = 64;
  localparam int unsigned DataDepth = 1024;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned MaxMatches = 63;
  localparam int unsigned ProgWidth = 39;

  typedef enum logic [1:0] {
    CMD_PROG = 2'd0,
    CMD_DATA = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_MATCH  = 3'd0,
    OP_LIT    = 3'd1,
    OP_MASKED = 3'd2,
    OP_ANY    = 3'd3,
    OP_REPEAT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_DONE     = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TOO_MANY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_POP_WAIT,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_REP_NEXT,
    S_REP_TEST,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

### hdl/mbpm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mbpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/masked_byte_pattern_matcher_unit.sv
// Top level of the masked byte pattern matcher: command decode, run sequencer and stores.
`default_nettype none
// Program and data writes give no result. A run walks the program through
// the program, data and backtrack memories, each with registered read data:
// a program step passes FETCH, DECODE and EXEC, a pop passes POP and
// POP_WAIT, and each repeat-any alternative tested passes REP_NEXT and
// REP_TEST, so the length of a run is set by the program, the data and the
// paths it backtracks through. busy stays high until the last result of a run;
// results appear for one cycle on valid_o and the receiver cannot stall them.
module masked_byte_pattern_matcher_unit #(
  parameter int unsigned PROG_DEPTH  = mbpm_pkg::ProgDepth,
  parameter int unsigned DATA_DEPTH  = mbpm_pkg::DataDepth,
  parameter int unsigned STACK_DEPTH = mbpm_pkg::StackDepth,
  parameter int unsigned MAX_MATCHES = mbpm_pkg::MaxMatches
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [9:0]  index_i,
  input  wire logic [2:0]  op_kind_i,
  input  wire logic [7:0]  lit_value_i,
  input  wire logic [7:0]  lit_mask_i,
  input  wire logic [9:0]  rep_min_i,
  input  wire logic [9:0]  rep_max_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [10:0] start_pos_i,
  input  wire logic [10:0] max_length_i,
  input  wire logic        backwards_i,
  input  wire logic        exhaustive_i,
  output logic             valid_o,
  output logic [1:0]       status_o,
  output logic [10:0]      match_start_o,
  output logic [10:0]      match_length_o,
  output logic             last_o
);
  localparam int unsigned PAW = (PROG_DEPTH > 1) ? $clog2(PROG_DEPTH) : 1;
  localparam int unsigned DAW = $clog2(DATA_DEPTH);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IPW = PAW + 1;
  localparam int unsigned NW  = 12;
  localparam int unsigned SW  = IPW + NW;
  localparam int unsigned MCW = 6;

  mbpm_pkg::state_e state_q, state_d;

  logic [IPW-1:0] ip_q, ip_d;
  logic [NW-1:0]  n_q, n_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [MCW-1:0] mc_q, mc_d;
  logic [10:0]    start_q, maxlen_q;
  logic           back_q, exh_q;
  logic [38:0]    ent_q, ent_d;       // current entry
  logic [2:0]     nxk_q, nxk_d;       // kind of the entry after a repeat
  logic [7:0]     nxv_q, nxv_d;
  logic [NW-1:0]  ri_q, ri_d;         // repeat skip under test
  logic           rep_q, rep_d;       // fetching for repeat next entry

  logic           accept;
  logic [1:0]     res_st;
  logic [10:0]    res_start, res_len;
  logic           res_valid, res_last;

  // Program memory.
  logic           pwe;
  logic [PAW-1:0] praddr;
  logic [38:0]    prdata;
  // Data memory.
  logic           dwe;
  logic [DAW-1:0] draddr;
  logic [7:0]     drdata;
  // Stack memory.
  logic           swe;
  logic [SAW-1:0] swaddr, sraddr;
  logic [SW-1:0]  swdata, srdata;

  assign accept = start && !busy;
  assign busy   = (state_q != mbpm_pkg::S_IDLE);
  assign pwe    = accept && (cmd_i == mbpm_pkg::CMD_PROG) &&
                  ({22'd0, index_i} < 32'(PROG_DEPTH));
  assign dwe    = accept && (cmd_i == mbpm_pkg::CMD_DATA) &&
                  ({22'd0, index_i} < 32'(DATA_DEPTH));

  mbpm_ram #(.Width(mbpm_pkg::ProgWidth), .Depth(PROG_DEPTH)) u_prog (
    .clk_i, .we_i(pwe), .waddr_i(index_i[PAW-1:0]),
    .wdata_i({op_kind_i, lit_value_i, lit_mask_i, rep_min_i, rep_max_i}),
    .raddr_i(praddr), .rdata_o(prdata));

  logic [DAW-1:0] dwaddr;
  always_comb begin
    dwaddr = '0;
    dwaddr = DAW'({22'd0, index_i});
  end
  mbpm_ram #(.Width(8), .Depth(DATA_DEPTH)) u_data (
    .clk_i, .we_i(dwe), .waddr_i(dwaddr), .wdata_i(data_byte_i),
    .raddr_i(draddr), .rdata_o(drdata));

  mbpm_ram #(.Width(SW), .Depth(STACK_DEPTH)) u_stack (
    .clk_i, .we_i(swe), .waddr_i(swaddr), .wdata_i(swdata),
    .raddr_i(sraddr), .rdata_o(srdata));

  // Entry fields.
  logic [2:0]  e_kind;
  logic [7:0]  e_val, e_msk;
  logic [9:0]  e_min, e_max;
  assign {e_kind, e_val, e_msk, e_min, e_max} = ent_q;

  // Data position of byte count m: start+m forward, start-1-m backward.
  function automatic logic [DAW-1:0] pos_f(input logic [10:0] s, input logic [NW-1:0] m,
                                           input logic b);
    logic [31:0] p;
    begin
      p = b ? (32'(s) - 32'd1 - 32'(m)) : (32'(s) + 32'(m));
      return p[DAW-1:0];
    end
  endfunction

  logic [NW-1:0] n_plus_ri;
  logic [NW-1:0] lo_sum;
  logic          ip_ok;
  assign n_plus_ri = n_q + ri_q;
  assign lo_sum    = n_q + NW'(e_min);
  assign ip_ok     = (32'(ip_q) < 32'(PROG_DEPTH));

  always_comb begin
    state_d = state_q;
    ip_d = ip_q; n_d = n_q; sp_d = sp_q; mc_d = mc_q;
    ent_d = ent_q; nxk_d = nxk_q; nxv_d = nxv_q; ri_d = ri_q; rep_d = rep_q;
    praddr = ip_q[PAW-1:0];
    draddr = pos_f(start_q, n_q, back_q);
    sraddr = SAW'(sp_q - SPW'(1));
    swe = 1'b0; swaddr = sp_q[SAW-1:0]; swdata = {ip_q + IPW'(1), n_plus_ri};
    res_valid = 1'b0; res_st = mbpm_pkg::ST_DONE; res_start = '0; res_len = '0;
    res_last = 1'b1;
    unique case (state_q)
      mbpm_pkg::S_IDLE: begin
        if (accept && cmd_i == mbpm_pkg::CMD_RUN) begin
          ip_d = '0; n_d = '0; sp_d = '0; mc_d = '0;
          state_d = mbpm_pkg::S_FETCH;
        end
      end
      mbpm_pkg::S_POP: begin
        if (sp_q == '0) begin
          res_valid = 1'b1;
          state_d = mbpm_pkg::S_IDLE;
        end else begin
          sp_d = sp_q - SPW'(1);
          state_d = mbpm_pkg::S_POP_WAIT;
        end
      end
      mbpm_pkg::S_POP_WAIT: begin
        ip_d = srdata[SW-1:NW];
        n_d  = srdata[NW-1:0];
        state_d = mbpm_pkg::S_FETCH;
      end
      mbpm_pkg::S_FETCH: begin
        // Program and data reads issued here land in DECODE.
        rep_d = 1'b0;
        if (!ip_ok) state_d = mbpm_pkg::S_POP;
        else state_d = mbpm_pkg::S_DECODE;
      end
      mbpm_pkg::S_DECODE: begin
        ent_d = prdata;
        state_d = mbpm_pkg::S_EXEC;
        if (rep_q) begin
          nxk_d = ip_ok ? prdata[38:36] : 3'd7;
          nxv_d = prdata[35:28];
          ri_d = NW'(e_min) + NW'(1);
          ent_d = ent_q;
          state_d = mbpm_pkg::S_REP_NEXT;
        end
      end
      mbpm_pkg::S_EXEC: begin
        if (e_kind == mbpm_pkg::OP_MATCH) begin
          res_valid = 1'b1;
          res_st = mbpm_pkg::ST_MATCH;
          res_start = back_q ? 11'(start_q - n_q[10:0]) : start_q;
          res_len = (n_q > NW'(2047)) ? 11'd2047 : n_q[10:0];
          if (!exh_q) begin
            state_d = mbpm_pkg::S_IDLE;
          end else if (32'(mc_q) >= 32'(MAX_MATCHES)) begin
            res_st = mbpm_pkg::ST_TOO_MANY; res_start = '0; res_len = '0;
            state_d = mbpm_pkg::S_IDLE;
          end else begin
            res_last = 1'b0;
            mc_d = mc_q + MCW'(1);
            state_d = mbpm_pkg::S_POP;
          end
        end else if (n_q >= NW'(maxlen_q)) begin
          state_d = mbpm_pkg::S_POP;
        end else begin
          priority case (e_kind)
            mbpm_pkg::OP_LIT, mbpm_pkg::OP_MASKED: begin
              if ((drdata & ((e_kind == mbpm_pkg::OP_LIT) ? 8'hFF : e_msk)) == e_val) begin
                n_d = n_q + NW'(1); ip_d = ip_q + IPW'(1);
                state_d = mbpm_pkg::S_FETCH;
              end else state_d = mbpm_pkg::S_POP;
            end
            mbpm_pkg::OP_ANY: begin
              n_d = n_q + NW'(1); ip_d = ip_q + IPW'(1);
              state_d = mbpm_pkg::S_FETCH;
            end
            mbpm_pkg::OP_REPEAT: begin
              // Fetch the following entry to filter the alternatives.
              praddr = PAW'(ip_q + IPW'(1));
              ip_d = ip_q + IPW'(1);
              rep_d = 1'b1;
              state_d = mbpm_pkg::S_DECODE;
            end
            default: state_d = mbpm_pkg::S_POP;
          endcase
        end
      end
      mbpm_pkg::S_REP_NEXT: begin
        // ip_q already points past the repeat entry here.
        draddr = pos_f(start_q, n_plus_ri, back_q);
        if (ri_q > NW'(e_max) || n_plus_ri >= NW'(maxlen_q)) begin
          n_d = lo_sum;
          state_d = mbpm_pkg::S_FETCH;
        end else begin
          state_d = mbpm_pkg::S_REP_TEST;
        end
      end
      mbpm_pkg::S_REP_TEST: begin
        swdata = {ip_q, n_plus_ri};
        if (nxk_q != mbpm_pkg::OP_LIT || nxv_q == drdata) begin
          if (32'(sp_q) >= 32'(STACK_DEPTH)) begin
            res_valid = 1'b1; res_st = mbpm_pkg::ST_OVERFLOW;
            state_d = mbpm_pkg::S_IDLE;
          end else begin
            swe = 1'b1;
            sp_d = sp_q + SPW'(1);
          end
        end
        if (state_d != mbpm_pkg::S_IDLE) begin
          ri_d = ri_q + NW'(1);
          state_d = mbpm_pkg::S_REP_NEXT;
        end
      end
      default: state_d = mbpm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbpm_pkg::S_IDLE;
      sp_q <= '0;
      mc_q <= '0;
      rep_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q <= sp_d;
      mc_q <= mc_d;
      rep_q <= rep_d;
      valid_o <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ip_q <= ip_d; n_q <= n_d; ent_q <= ent_d;
    nxk_q <= nxk_d; nxv_q <= nxv_d; ri_q <= ri_d;
    status_o <= res_st; match_start_o <= res_start;
    match_length_o <= res_len; last_o <= res_last;
    if (accept) begin
      start_q <= start_pos_i; maxlen_q <= max_length_i;
      back_q <= backwards_i; exh_q <= exhaustive_i;
    end
  end

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) <= 32'(STACK_DEPTH)) else $error("stack pointer beyond depth");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    swe |-> 32'(sp_q) < 32'(STACK_DEPTH)) else $error("push onto full stack");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy) else $error("busy after last result");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mc_q) <= 32'(MAX_MATCHES)) else $error("match count over cap");
endmodule
`default_nettype wire
